// ----- design/grid_ray_dda_walker_macros.svh -----
// assertion helpers for the grid ray walker
`ifndef GRID_RAY_DDA_WALKER_MACROS_SVH
`define GRID_RAY_DDA_WALKER_MACROS_SVH
`define GRW_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define GRW_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ----- design/grw_pkg.sv -----
// ----------------------------------------------------------------------------
// grw_pkg
// shared types and constants of the grid ray walker
// ----------------------------------------------------------------------------
`default_nettype none
package grw_pkg;
	localparam int DIST_W = 24;
	localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;
	localparam int DIV_N = 48;
	localparam int DIV_D = 32;

	localparam logic [3:0] REG_CELL_SIZE  = 4'd0;
	localparam logic [3:0] REG_MAP_WIDTH  = 4'd1;
	localparam logic [3:0] REG_MAP_HEIGHT = 4'd2;
	localparam logic [3:0] REG_CAST_LIMIT = 4'd3;

	localparam logic [1:0] FACE_X_NEG = 2'd0;
	localparam logic [1:0] FACE_Y_NEG = 2'd1;
	localparam logic [1:0] FACE_X_POS = 2'd2;
	localparam logic [1:0] FACE_Y_POS = 2'd3;

	typedef struct packed {
		logic [23:0]        pos_x;
		logic [23:0]        pos_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
	} ray_t;

	typedef struct packed {
		logic signed [11:0] cell_x;
		logic signed [11:0] cell_y;
		logic [1:0]         face;
		logic [23:0]        cross_dist;
		logic               edge_hit;
		logic               last;
	} hit_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

	function automatic logic [DIST_W-1:0] sat24(input logic [DIV_N-1:0] v);
		logic [DIST_W-1:0] r;
		r = (v > DIV_N'(DIST_MAX)) ? DIST_MAX : v[DIST_W-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- design/grw_div_cell.sv -----
// ----------------------------------------------------------------------------
// grw_div_cell
// one restoring divider per instance; each enabled step shifts in one of the quotient bits
// ----------------------------------------------------------------------------
`default_nettype none
module grw_div_cell (
	input  wire logic                         clk,
	input  wire logic                         load,
	input  wire logic                         en,
	input  wire logic [grw_pkg::DIV_N-1:0]    num,
	input  wire logic [grw_pkg::DIV_D-1:0]    den,
	output logic      [grw_pkg::DIV_N-1:0]    quo
);
	localparam int NW = grw_pkg::DIV_N;
	localparam int DW = grw_pkg::DIV_D;

	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   trial;
	logic [DW:0]   sh;

	always_comb begin
		sh = {r_q[DW-1:0], q_q[NW-1]};
		trial = sh - {1'b0, d_q};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (en) begin
			if (!trial[DW]) begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule
`default_nettype wire

// ----- design/grw_axis_cell.sv -----
// ----------------------------------------------------------------------------
// grw_axis_cell
// per-axis walker cell: side distance, delta and cell index
// ----------------------------------------------------------------------------
`default_nettype none
module grw_axis_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire logic               adv,
	input  wire logic [23:0]        side_in,
	input  wire logic [23:0]        delta_in,
	input  wire logic signed [11:0] cell_in,
	input  wire logic               neg_in,
	output logic      [23:0]        side,
	output logic signed [11:0]      cell_next,
	output logic                    neg
);
	logic [23:0]        side_q;
	logic [23:0]        delta_q;
	logic signed [11:0] cell_q;
	logic               neg_q;
	logic [24:0]        sum;

	assign sum = {1'b0, side_q} + {1'b0, delta_q};
	assign cell_next = neg_q ? cell_q - 12'sd1 : cell_q + 12'sd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
			delta_q <= '0;
			cell_q <= '0;
			neg_q <= 1'b0;
		end else if (load) begin
			side_q <= side_in;
			delta_q <= delta_in;
			cell_q <= cell_in;
			neg_q <= neg_in;
		end else if (adv) begin
			side_q <= sum[24] ? grw_pkg::DIST_MAX : sum[23:0];
			cell_q <= cell_next;
		end
	end

	assign side = side_q;
	assign neg = neg_q;
endmodule
`default_nettype wire

// ----- design/grid_ray_dda_walker.sv -----
// ----------------------------------------------------------------------------
// grid_ray_dda_walker
// grid ray traversal: setup by serial division, then, unless hit stalls, one crossing a cycle
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// ray     | in  | ray_valid/ready  | grw_pkg::ray_t
// hit     | out | hit_valid/ready  | grw_pkg::hit_t
// cfg     | in  | cfg_we           | cfg_index, cfg_data
// setup runs three divisions back to back on two serial dividers (one per
// axis): start cell, line spacing, first-line distance. the first hit beat
// is registered once setup ends, then one crossing per cycle up to the cast
// limit or the map edge while hit_ready stays high.
// a stall on hit holds the walk; a new ray is taken only in idle.
// reset clears control state and the config registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "grid_ray_dda_walker_macros.svh"
module grid_ray_dda_walker #(
	parameter int MAX_MAP_DIM = 1024,
	parameter int MAX_CAST = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          ray_valid,
	output logic               ray_ready,
	input  wire grw_pkg::ray_t ray,
	output logic               hit_valid,
	input  wire logic          hit_ready,
	output grw_pkg::hit_t      hit,
	input  wire logic          cfg_we,
	input  wire logic [3:0]    cfg_index,
	input  wire logic [15:0]   cfg_data
);
	localparam int NW = grw_pkg::DIV_N;
	localparam int DW = grw_pkg::DIV_D;
	localparam int CNT_W = $clog2(NW + 2);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CELL = 6'b000010,
		ST_DLT  = 6'b000100,
		ST_SIDE = 6'b001000,
		ST_WALK = 6'b010000,
		ST_OFF  = 6'b100000
	} state_t;

	state_t state_q;
	logic [15:0] cell_size_q;
	logic [10:0] map_width_q, map_height_q;
	logic [6:0]  cast_limit_q;
	grw_pkg::ray_t ray_q;
	logic [CNT_W-1:0] cnt_q;
	logic [6:0] steps_q;
	logic [6:0] lim_q;
	logic signed [11:0] w_q, h_q;
	logic [23:0] remx_q, remy_q;
	logic signed [11:0] colx_q, rowy_q;
	logic [23:0] dlx_q, dly_q;
	grw_pkg::div_ctl_t dctl;

	logic [15:0] cs;
	logic [15:0] magx, magy;
	logic nearx, neary, negx, negy;
	logic [23:0] fx, fy;

	assign cs = (cell_size_q == 16'd0) ? 16'd1 : cell_size_q;
	assign magx = ray_q.dir_x[15] ? 16'(-ray_q.dir_x) : ray_q.dir_x;
	assign magy = ray_q.dir_y[15] ? 16'(-ray_q.dir_y) : ray_q.dir_y;
	// |dir| * 1000 < 16384 means |dir| <= 16
	assign nearx = magx < 16'd17;
	assign neary = magy < 16'd17;
	assign negx = ray_q.dir_x[15];
	assign negy = ray_q.dir_y[15];
	assign fx = negx ? remx_q : 24'(cs) - remx_q;
	assign fy = negy ? remy_q : 24'(cs) - remy_q;

	logic dload;
	logic div_en;
	logic [NW-1:0] numx, numy, qx, qy;
	logic [DW-1:0] denx, deny;

	assign dctl.start = dload;
	assign dctl.busy = (cnt_q != '0);
	assign dctl.done = (cnt_q == CNT_W'(1));
	// the count runs one past the quotient bits so done sees a full quotient
	assign div_en = dctl.busy && !dctl.done;

	always_comb begin
		numx = '0; numy = '0; denx = 32'd1; deny = 32'd1;
		unique case (state_q)
			ST_IDLE: begin
				numx = NW'(ray.pos_x);
				numy = NW'(ray.pos_y);
				denx = DW'(cell_size_q == 16'd0 ? 16'd1 : cell_size_q);
				deny = denx;
			end
			ST_CELL: begin
				numx = NW'(cs) << 14;
				numy = NW'(cs) << 14;
				denx = DW'(magx);
				deny = DW'(magy);
			end
			ST_DLT: begin
				numx = nearx ? NW'(fx) * NW'(64'd2560000000) : NW'(fx) << 14;
				numy = neary ? NW'(fy) * NW'(64'd2560000000) : NW'(fy) << 14;
				denx = nearx ? DW'(cs) : DW'(magx);
				deny = neary ? DW'(cs) : DW'(magy);
			end
			default: ;
		endcase
	end

	grw_div_cell u_divx (.clk, .load(dload), .en(div_en), .num(numx), .den(denx),
		.quo(qx));
	grw_div_cell u_divy (.clk, .load(dload), .en(div_en), .num(numy), .den(deny),
		.quo(qy));

	logic ax_load, ax_adv, ay_adv;
	logic [23:0] sx, sy;
	logic signed [11:0] nxc, nyc;
	logic nx_neg, ny_neg;
	logic [23:0] sxi, syi;

	assign sxi = grw_pkg::sat24(qx);
	assign syi = grw_pkg::sat24(qy);

	grw_axis_cell u_ax (.clk, .arst_n, .load(ax_load), .adv(ax_adv), .side_in(sxi),
		.delta_in(nearx ? grw_pkg::DIST_MAX : dlx_q), .cell_in(colx_q), .neg_in(negx),
		.side(sx), .cell_next(nxc), .neg(nx_neg));
	grw_axis_cell u_ay (.clk, .arst_n, .load(ax_load), .adv(ay_adv), .side_in(syi),
		.delta_in(neary ? grw_pkg::DIST_MAX : dly_q), .cell_in(rowy_q), .neg_in(negy),
		.side(sy), .cell_next(nyc), .neg(ny_neg));

	logic take_x, go, edge_c, last_c;
	logic signed [11:0] ncx, ncy;
	logic out_free;

	assign out_free = !hit_valid || hit_ready;
	assign take_x = sx < sy;
	assign go = (state_q == ST_WALK) && out_free;
	assign ax_adv = go && take_x;
	assign ay_adv = go && !take_x;
	assign ncx = take_x ? nxc : colx_q;
	assign ncy = take_x ? rowy_q : nyc;
	assign edge_c = ncx < 12'sd0 || ncx >= w_q || ncy < 12'sd0 || ncy >= h_q;
	assign last_c = edge_c || (steps_q + 7'd1 >= lim_q);
	assign ax_load = dctl.done && (state_q == ST_SIDE);
	assign dload = (state_q == ST_IDLE && ray_valid)
		|| (dctl.done && (state_q == ST_CELL || state_q == ST_DLT));
	assign ray_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= 16'd256;
			map_width_q <= 11'd64;
			map_height_q <= 11'd64;
			cast_limit_q <= 7'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grw_pkg::REG_CELL_SIZE:  cell_size_q <= cfg_data;
				grw_pkg::REG_MAP_WIDTH:  map_width_q <= cfg_data[10:0];
				grw_pkg::REG_MAP_HEIGHT: map_height_q <= cfg_data[10:0];
				grw_pkg::REG_CAST_LIMIT: cast_limit_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			hit_valid <= 1'b0;
			steps_q <= '0;
		end else begin
			if (go || (state_q == ST_OFF && out_free)) hit_valid <= 1'b1;
			else if (hit_ready) hit_valid <= 1'b0;
			if (dload) cnt_q <= CNT_W'(NW + 1);
			else if (dctl.busy) cnt_q <= cnt_q - CNT_W'(1);
			unique case (state_q)
				ST_IDLE: if (ray_valid) state_q <= ST_CELL;
				ST_CELL: if (dctl.done) state_q <= ST_DLT;
				ST_DLT:  if (dctl.done) state_q <= ST_SIDE;
				ST_SIDE: if (dctl.done) begin
					steps_q <= '0;
					state_q <= (colx_q >= w_q || rowy_q >= h_q) ? ST_OFF : ST_WALK;
				end
				ST_OFF: if (out_free) begin
					state_q <= ST_IDLE;
				end
				ST_WALK: if (out_free) begin
					steps_q <= steps_q + 7'd1;
					if (last_c) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [23:0] remx_n, remy_n;
	assign remx_n = 24'(ray_q.pos_x - qx[23:0] * 24'(cs));
	assign remy_n = 24'(ray_q.pos_y - qy[23:0] * 24'(cs));

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && ray_valid) begin
			ray_q <= ray;
			w_q <= (int'(map_width_q) > MAX_MAP_DIM) ? 12'(MAX_MAP_DIM)
				: 12'(map_width_q);
			h_q <= (int'(map_height_q) > MAX_MAP_DIM) ? 12'(MAX_MAP_DIM)
				: 12'(map_height_q);
			lim_q <= (cast_limit_q == 7'd0) ? 7'd1
				: (int'(cast_limit_q) > MAX_CAST) ? 7'(MAX_CAST) : cast_limit_q;
		end
		if (state_q == ST_CELL && dctl.done) begin
			// start cells past any map width clamp to 2047
			colx_q <= (qx > NW'(2047)) ? 12'sd2047 : 12'(qx);
			rowy_q <= (qy > NW'(2047)) ? 12'sd2047 : 12'(qy);
			remx_q <= remx_n;
			remy_q <= remy_n;
		end
		if (state_q == ST_DLT && dctl.done) begin
			dlx_q <= grw_pkg::sat24(qx);
			dly_q <= grw_pkg::sat24(qy);
		end
		if (ax_adv) colx_q <= nxc;
		if (ay_adv) rowy_q <= nyc;
		if (state_q == ST_OFF && out_free) begin
			hit.cell_x <= (colx_q > w_q) ? w_q : colx_q;
			hit.cell_y <= (rowy_q > h_q) ? h_q : rowy_q;
			hit.face <= grw_pkg::FACE_X_NEG;
			hit.cross_dist <= '0;
			hit.edge_hit <= 1'b1;
			hit.last <= 1'b1;
		end else if (go) begin
			hit.cell_x <= ncx;
			hit.cell_y <= ncy;
			hit.face <= take_x ? (nx_neg ? grw_pkg::FACE_X_POS : grw_pkg::FACE_X_NEG)
				: (ny_neg ? grw_pkg::FACE_Y_POS : grw_pkg::FACE_Y_NEG);
			hit.cross_dist <= take_x ? sx : sy;
			hit.edge_hit <= edge_c;
			hit.last <= last_c;
		end
	end

	`GRW_ASSERT_IMP(a_no_ready_busy, clk, arst_n, state_q != ST_IDLE, !ray_ready,
		"ray accepted while busy")
	`GRW_ASSERT_IMP(a_div_idle_walk, clk, arst_n, state_q == ST_WALK, !dctl.busy,
		"divider running during walk")
	`GRW_ASSERT_NXT(a_hold_stall, clk, arst_n, hit_valid && !hit_ready, hit_valid,
		"hit beat dropped")
	`GRW_ASSERT_IMP(a_steps_lim, clk, arst_n, state_q == ST_WALK, steps_q < lim_q,
		"walk past cast limit")
endmodule
`default_nettype wire
